### rtl/lz77_token_decompressor_assert.svh
// Assertion macros shared by the lz77 token decompressor RTL
`ifndef LZ77_TOKEN_DECOMPRESSOR_ASSERT_SVH
`define LZ77_TOKEN_DECOMPRESSOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define LZ77TD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define LZ77TD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/lz77td_pkg.sv
// Shared types and constants for the lz77 token decompressor
`timescale 1ns / 1ps

package lz77td_pkg;

	// History window and token format
	localparam int WINDOW_DEPTH = 512;
	localparam int HIST_AW      = $clog2(WINDOW_DEPTH);
	localparam int LENGTH_BITS  = 7;
	localparam int OFFSET_BITS  = 16 - LENGTH_BITS;

	// Output counter and limit register
	localparam int COUNT_W = 20;
	localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
	localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(65536);

	localparam logic [LENGTH_BITS-1:0] MIN_MATCH = LENGTH_BITS'(3);
	localparam logic [7:0] LIT_FLAG = 8'h80;
	localparam logic [7:0] LIT_MASK = 8'h7F;

	// Command queue between parser and executor
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_LIT,
		CMD_MATCH
	} cmd_kind_t;

	// One parsed item: code is the literal or the next byte of a match
	typedef struct packed {
		cmd_kind_t   kind;
		logic        start;
		logic [7:0]  code;
		logic [15:0] word;
	} cmd_t;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       stream_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte_first;
		logic [7:0] out_byte_second;
		logic [1:0] byte_count;
		logic       last_of_run;
		logic       error_flag;
	} out_item_t;

endpackage

### rtl/lz77td_front.sv
// Token parser: accepts compressed bytes and turns them into commands
`timescale 1ns / 1ps

module lz77td_front import lz77td_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_item,
	input  logic     q_full,
	output logic     q_push,
	output cmd_t     q_cmd
);

	typedef enum logic [1:0] {
		PH_FIRST,
		PH_SECOND,
		PH_NEXT
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [7:0] first_q;
	logic [7:0] second_q;
	phase_t     cur_phase;
	logic       take_first;
	logic       take_second;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	// Classify the byte against the current parse phase
	always_comb begin
		cur_phase   = in_item.stream_start ? PH_FIRST : phase_q;
		phase_d     = PH_FIRST;
		take_first  = 1'b0;
		take_second = 1'b0;
		q_cmd.kind  = CMD_HOLD;
		q_cmd.start = in_item.stream_start;
		q_cmd.code  = in_item.code_byte;
		q_cmd.word  = {first_q, second_q};
		case (cur_phase)
			PH_SECOND: begin
				take_second = 1'b1;
				phase_d     = PH_NEXT;
			end
			PH_NEXT: begin
				q_cmd.kind = CMD_MATCH;
			end
			default: begin
				if ((in_item.code_byte & LIT_FLAG) != 8'h00) begin
					q_cmd.kind = CMD_LIT;
					q_cmd.code = in_item.code_byte & LIT_MASK;
				end else begin
					take_first = 1'b1;
					phase_d    = PH_SECOND;
				end
			end
		endcase
	end

	// Phase and held header bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_FIRST;
			first_q  <= 8'h00;
			second_q <= 8'h00;
		end else if (q_push) begin
			phase_q <= phase_d;
			if (take_first) first_q <= in_item.code_byte;
			if (take_second) second_q <= in_item.code_byte;
		end
	end

endmodule

### rtl/lz77td_queue.sv
// Short command queue between the parser and the executor
`timescale 1ns / 1ps

module lz77td_queue import lz77td_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output cmd_t head_cmd
);

	cmd_t              entry_q [Q_DEPTH];
	logic [Q_AW-1:0]   wr_ptr_q;
	logic [Q_AW-1:0]   rd_ptr_q;
	logic [Q_AW:0]     count_q;

	assign full      = count_q == (Q_AW+1)'(Q_DEPTH);
	assign not_empty = count_q != '0;
	assign head_cmd  = entry_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_cmd;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

### rtl/lz77td_back.sv
// Executor: history window, match copy, limit checks and result packing
`timescale 1ns / 1ps

module lz77td_back import lz77td_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  cmd_t               q_cmd,
	output logic               q_pop,
	input  logic [COUNT_W-1:0] output_limit,
	output logic               out_valid,
	input  logic               out_ready,
	output out_item_t          out_item
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_COPY_RD,
		ST_COPY_WR,
		ST_NEXT
	} state_t;

	state_t                 state_q;
	cmd_t                   cmd_q;
	logic [COUNT_W-1:0]     produced_q;
	logic [HIST_AW-1:0]     wp_q;
	logic                   halted_q;
	logic [HIST_AW-1:0]     src_q;
	logic [LENGTH_BITS-1:0] cnt_q;
	logic [7:0]             pend_q;
	logic                   pend_valid_q;
	logic                   out_valid_q;
	out_item_t              out_q;
	logic [7:0]             rd_q;
	logic [7:0]             hist_mem [WINDOW_DEPTH];

	logic [LENGTH_BITS-1:0] len;
	logic [OFFSET_BITS-1:0] off;
	logic [COUNT_W-1:0]     off_w;
	logic [COUNT_W-1:0]     len_w;
	logic                   bad_match;
	logic                   long_match;
	logic [COUNT_W-1:0]     prod_inc;
	logic                   slot_free;
	logic                   over_now;
	logic                   over_next;
	logic                   last_copy;
	logic                   emit;
	out_item_t              res;
	logic                   mem_we;
	logic [7:0]             mem_wdata;
	logic                   mem_rd;

	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// Token fields and checks
	assign len        = cmd_q.word[LENGTH_BITS-1:0];
	assign off        = cmd_q.word[15:LENGTH_BITS];
	assign off_w      = COUNT_W'(off);
	assign len_w      = COUNT_W'(len);
	assign long_match = len >= MIN_MATCH;
	assign bad_match  = (off_w > produced_q) || (off_w > COUNT_W'(WINDOW_DEPTH))
		|| (len_w > off_w);
	assign prod_inc   = (produced_q == COUNT_MAX) ? produced_q : produced_q + 1'b1;
	assign slot_free  = !out_valid_q || out_ready;
	assign over_now   = produced_q >= output_limit;
	assign over_next  = prod_inc >= output_limit;
	assign last_copy  = cnt_q == LENGTH_BITS'(1);

	// Result, history write and read strobes for this cycle
	always_comb begin
		emit      = 1'b0;
		res       = '0;
		mem_we    = 1'b0;
		mem_wdata = cmd_q.code;
		mem_rd    = 1'b0;
		case (state_q)
			ST_DISPATCH: begin
				if (halted_q || (cmd_q.kind == CMD_MATCH && long_match && bad_match)) begin
					emit            = slot_free;
					res.last_of_run = 1'b1;
					res.error_flag  = 1'b1;
				end
			end
			ST_COPY_RD: begin
				mem_rd = 1'b1;
			end
			ST_COPY_WR: begin
				mem_wdata = rd_q;
				if (!pend_valid_q) begin
					mem_we = 1'b1;
				end else begin
					// Pair complete; the final pair closes the run if the next byte overflows
					emit                = slot_free;
					mem_we              = slot_free;
					res.out_byte_first  = pend_q;
					res.out_byte_second = rd_q;
					res.byte_count      = 2'd2;
					res.last_of_run     = last_copy && over_next;
					res.error_flag      = last_copy && over_next;
				end
			end
			ST_NEXT: begin
				emit            = slot_free;
				res.last_of_run = 1'b1;
				if (over_now) begin
					res.error_flag = 1'b1;
					if (pend_valid_q) begin
						res.out_byte_first = pend_q;
						res.byte_count     = 2'd1;
					end
				end else begin
					mem_we = slot_free;
					if (pend_valid_q) begin
						res.out_byte_first  = pend_q;
						res.out_byte_second = cmd_q.code;
						res.byte_count      = 2'd2;
					end else begin
						res.out_byte_first = cmd_q.code;
						res.byte_count     = 2'd1;
					end
				end
			end
			default: ;
		endcase
	end

	// History window, registered read
	always_ff @(posedge clk) begin
		if (mem_we) hist_mem[wp_q] <= mem_wdata;
		if (mem_rd) rd_q <= hist_mem[src_q];
	end

	// Sequencer, counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cmd_q        <= '0;
			produced_q   <= '0;
			wp_q         <= '0;
			halted_q     <= 1'b0;
			src_q        <= '0;
			cnt_q        <= '0;
			pend_q       <= 8'h00;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				out_q       <= res;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (mem_we) begin
				wp_q       <= wp_q + 1'b1;
				produced_q <= prod_inc;
			end

			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						cmd_q        <= q_cmd;
						pend_valid_q <= 1'b0;
						if (q_cmd.start) begin
							produced_q <= '0;
							wp_q       <= '0;
							halted_q   <= 1'b0;
						end
						state_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					if (halted_q) begin
						if (slot_free) state_q <= ST_IDLE;
					end else begin
						case (cmd_q.kind)
							CMD_LIT: state_q <= ST_NEXT;
							CMD_MATCH: begin
								if (!long_match) begin
									state_q <= ST_NEXT;
								end else if (bad_match) begin
									if (slot_free) begin
										halted_q <= 1'b1;
										state_q  <= ST_IDLE;
									end
								end else begin
									src_q   <= wp_q - HIST_AW'(off);
									cnt_q   <= len;
									state_q <= ST_COPY_RD;
								end
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_COPY_RD: begin
					src_q   <= src_q + 1'b1;
					state_q <= ST_COPY_WR;
				end
				ST_COPY_WR: begin
					if (!pend_valid_q) begin
						pend_q       <= rd_q;
						pend_valid_q <= 1'b1;
						cnt_q        <= cnt_q - 1'b1;
						state_q      <= last_copy ? ST_NEXT : ST_COPY_RD;
					end else if (slot_free) begin
						pend_valid_q <= 1'b0;
						cnt_q        <= cnt_q - 1'b1;
						if (!last_copy) begin
							state_q <= ST_COPY_RD;
						end else if (over_next) begin
							halted_q <= 1'b1;
							state_q  <= ST_IDLE;
						end else begin
							state_q <= ST_NEXT;
						end
					end
				end
				ST_NEXT: begin
					if (slot_free) begin
						if (over_now) halted_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### rtl/lz77_token_decompressor.sv
// Top level of the lz77 token decompressor
//
//  channel   signals                         direction  contents
//  input     in_valid / in_ready / in_item   in         code_byte, stream_start
//  output    out_valid / out_ready / out_item out       up to two bytes, count, last, error
//  config    cfg_wr_en / cfg_wr_data         in         output_limit, no wait, no read-back
//
// The parser takes a new item whenever the queue is not full. In the executor a header byte
// or an error result passes ST_IDLE and ST_DISPATCH; a literal or a short match adds ST_NEXT.
// A long match copies each byte in ST_COPY_RD then ST_COPY_WR (read then write of the
// single-port history memory). The four-entry command queue lets the parser keep accepting
// while a copy runs; a full queue stalls it, and a held output register stalls the executor.
// Reset clears parser, queue, counters and error state; the history memory is not cleared.
`timescale 1ns / 1ps

module lz77_token_decompressor import lz77td_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  in_item_t           in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output out_item_t          out_item,
	input  logic               cfg_wr_en,
	input  logic [COUNT_W-1:0] cfg_wr_data
);

	`include "lz77_token_decompressor_assert.svh"

	logic [COUNT_W-1:0] limit_q;
	logic               q_full;
	logic               q_push;
	cmd_t               q_push_cmd;
	logic               q_pop;
	logic               q_valid;
	cmd_t               q_head;

	// Output limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	lz77td_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (q_push_cmd)
	);

	lz77td_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head_cmd  (q_head)
	);

	lz77td_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_cmd        (q_head),
		.q_pop        (q_pop),
		.output_limit (limit_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_item     (out_item)
	);

	// An empty result only ever reports an error and closes its run
	`LZ77TD_ASSERT_NOW(a_empty_is_error, out_valid && out_item.byte_count == 2'd0,
		out_item.error_flag && out_item.last_of_run, "empty result without error")
	// The error flag rides only on the final result of an item
	`LZ77TD_ASSERT_NOW(a_error_is_last, out_valid && out_item.error_flag,
		out_item.last_of_run, "error flag on a non-final result")
	// A result never claims more than two bytes
	`LZ77TD_ASSERT_NOW(a_count_range, out_valid, out_item.byte_count != 2'd3,
		"byte count out of range")
	// A pop without a push always leaves the queue not full
	`LZ77TD_ASSERT_NEXT(a_pop_not_full, q_pop && !q_push, !q_full,
		"queue full right after a pop")

endmodule

### test/lz77_decode_monitor.sv
// Channel monitor for the lz77 token decompressor: decodes accepted items and compares results
`timescale 1ns / 1ps

module lz77_decode_monitor import lz77td_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  in_item_t           in_item,
	input  logic               out_valid,
	input  logic               out_ready,
	input  out_item_t          out_item,
	input  logic               cfg_wr_en,
	input  logic [COUNT_W-1:0] cfg_wr_data,
	output int                 fails,
	output int                 pending
);

	typedef enum logic [1:0] {
		WANT_HEAD,
		WANT_WORD_LO,
		WANT_NEXT
	} token_phase_t;

	// Decoder state, mirrors what the block keeps
	logic [COUNT_W-1:0] limit_q;
	token_phase_t       phase_q;
	logic [7:0]         head_q;
	logic [7:0]         word_lo_q;
	logic [COUNT_W-1:0] produced_q;
	logic [7:0]         window_q [WINDOW_DEPTH];
	logic [HIST_AW-1:0] wptr_q;
	logic               halted_q;

	logic [7:0] run_q[$];
	out_item_t  decoded_q[$];
	int         mismatch_total = 0;

	// Append one decoded byte to the window and to this item's run
	function automatic void store_byte(logic [7:0] b);
		window_q[wptr_q] = b;
		wptr_q = wptr_q + 1'b1;
		if (produced_q != COUNT_MAX)
			produced_q = produced_q + 1'b1;
		run_q.push_back(b);
	endfunction

	// Literal and next-byte appends are the only ones checked against the limit
	function automatic void append_limited(logic [7:0] b);
		if (produced_q >= limit_q)
			halted_q = 1'b1;
		else
			store_byte(b);
	endfunction

	// Decode one item and queue the results it should produce
	task automatic decode_item(input in_item_t it);
		logic [15:0]            word;
		logic [LENGTH_BITS-1:0] len;
		logic [OFFSET_BITS-1:0] off;
		logic [7:0]             b;
		int                     nres;
		int                     first;
		int                     cnt;
		out_item_t              r;

		b = it.code_byte;
		if (it.stream_start) begin
			phase_q = WANT_HEAD;
			head_q = '0;
			word_lo_q = '0;
			produced_q = '0;
			wptr_q = '0;
			halted_q = 1'b0;
		end
		run_q.delete();

		// halted stream: one empty error result, nothing else changes
		if (halted_q) begin
			r = '0;
			r.last_of_run = 1'b1;
			r.error_flag = 1'b1;
			decoded_q.push_back(r);
			return;
		end

		case (phase_q)
			WANT_WORD_LO: begin
				word_lo_q = b;
				phase_q = WANT_NEXT;
			end
			WANT_NEXT: begin
				phase_q = WANT_HEAD;
				word = {head_q, word_lo_q};
				len = word[LENGTH_BITS-1:0];
				off = word[15:LENGTH_BITS];
				// bad offset or overlapping copy drops the whole token
				if (len >= MIN_MATCH && (off > produced_q || off > WINDOW_DEPTH || len > off)) begin
					halted_q = 1'b1;
				end else begin
					if (len >= MIN_MATCH)
						for (int i = 0; i < len; i++)
							store_byte(window_q[HIST_AW'(wptr_q - off)]);
					append_limited(b);
				end
			end
			default: begin
				if ((b & LIT_FLAG) != 8'h00) begin
					phase_q = WANT_HEAD;
					append_limited(b & LIT_MASK);
				end else begin
					head_q = b;
					phase_q = WANT_WORD_LO;
				end
			end
		endcase

		// pack the run two bytes per result
		nres = (run_q.size() + 1) / 2;
		if (nres == 0 && halted_q)
			nres = 1;
		for (int k = 0; k < nres; k++) begin
			first = 2 * k;
			if (run_q.size() - first >= 2)
				cnt = 2;
			else if (run_q.size() > first)
				cnt = 1;
			else
				cnt = 0;
			r.out_byte_first = (cnt >= 1) ? run_q[first] : 8'h00;
			r.out_byte_second = (cnt >= 2) ? run_q[first + 1] : 8'h00;
			r.byte_count = 2'(cnt);
			r.last_of_run = (k == nres - 1);
			r.error_flag = (k == nres - 1) && halted_q;
			decoded_q.push_back(r);
		end
	endtask

	function automatic int field_differs(string name, int exp_v, int got_v);
		if (exp_v == got_v)
			return 0;
		$error("%s: expected %0h, got %0h", name, exp_v, got_v);
		return 1;
	endfunction

	// Watch all three ports at each edge
	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_r;
		if (!arst_n) begin
			limit_q = LIMIT_RESET;
			phase_q = WANT_HEAD;
			head_q = '0;
			word_lo_q = '0;
			produced_q = '0;
			wptr_q = '0;
			halted_q = 1'b0;
			run_q.delete();
			decoded_q.delete();
			pending <= 0;
		end else begin
			if (cfg_wr_en)
				limit_q = cfg_wr_data;
			if (in_valid && in_ready)
				decode_item(in_item);
			if (out_valid && out_ready) begin
				if (decoded_q.size() == 0) begin
					$error("unexpected result: bytes %0h %0h, count %0d, last %0b, error %0b",
						out_item.out_byte_first, out_item.out_byte_second,
						out_item.byte_count, out_item.last_of_run, out_item.error_flag);
					mismatch_total++;
				end else begin
					exp_r = decoded_q.pop_front();
					mismatch_total += field_differs("out_byte_first",
						exp_r.out_byte_first, out_item.out_byte_first);
					mismatch_total += field_differs("out_byte_second",
						exp_r.out_byte_second, out_item.out_byte_second);
					mismatch_total += field_differs("byte_count",
						exp_r.byte_count, out_item.byte_count);
					mismatch_total += field_differs("last_of_run",
						exp_r.last_of_run, out_item.last_of_run);
					mismatch_total += field_differs("error_flag",
						exp_r.error_flag, out_item.error_flag);
				end
			end
			pending <= decoded_q.size();
		end
		fails <= mismatch_total;
	end

endmodule

### test/tb.sv
// Testbench top for the lz77 token decompressor: stimulus, idling phases and verdict
`timescale 1ns / 1ps

module tb;
	import lz77td_pkg::*;

	localparam int CLK_HALF      = 10;
	localparam int RESET_CYCLES  = 3;
	localparam int PHASE_ITEMS   = 78;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 40;
	localparam int DRAIN_CYCLES  = 300;
	localparam int TIMEOUT_NS    = 20_000_000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	in_item_t           in_item = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	out_item_t          out_item;
	logic               cfg_wr_en = 1'b0;
	logic [COUNT_W-1:0] cfg_wr_data = '0;

	int fails;
	int pending;

	// Stimulus knobs and bookkeeping
	int   gap_pct = 0;
	int   stall_pct = 0;
	int   hold_request = 0;
	int   items_sent = 0;
	int   stream_bytes = 0;
	logic start_next = 1'b0;

	always #(CLK_HALF) clk = ~clk;

	lz77_token_decompressor dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	lz77_decode_monitor decode_mon (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.fails      (fails),
		.pending    (pending)
	);

	// Offer one code byte, with random gaps before it; returns right after the accepting edge
	task automatic send_byte(input logic [7:0] b);
		while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= in_item_t'{code_byte: b, stream_start: start_next};
		start_next = 1'b0;
		items_sent++;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Three-byte match token: offset/length word, then the next byte
	task automatic send_match(input int off, input int len, input logic [7:0] next_b);
		logic [15:0] word;
		word = {OFFSET_BITS'(off), LENGTH_BITS'(len)};
		send_byte(word[15:8]);
		send_byte(word[7:0]);
		send_byte(next_b);
		if (len >= 3)
			stream_bytes += len;
		stream_bytes++;
	endtask

	// Stop offering and wait until every expected result has come out
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Limit write while idle; the next item opens a fresh stream
	task automatic write_limit(input logic [COUNT_W-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		start_next = 1'b1;
		stream_bytes = 0;
	endtask

	// One random token, mostly well formed
	task automatic random_token();
		int r;
		int maxoff;
		int lenmax;
		int off;
		int len;

		if ($urandom_range(19) == 0) begin
			start_next = 1'b1;
			stream_bytes = 0;
		end
		r = $urandom_range(99);
		if (r < 40 || (r < 80 && stream_bytes < 3)) begin
			send_byte(8'h80 | 8'($urandom_range(127)));
			stream_bytes++;
		end else if (r < 80) begin
			// valid copy; offset stays below 256 so the head byte reads as a match
			maxoff = (stream_bytes > 255) ? 255 : stream_bytes;
			if ($urandom_range(15) == 0)
				off = maxoff;
			else
				off = $urandom_range(3, maxoff);
			lenmax = (off > 127) ? 127 : off;
			if ($urandom_range(15) == 0)
				len = lenmax;
			else if ($urandom_range(7) == 0)
				len = $urandom_range(3, lenmax);
			else
				len = $urandom_range(3, (lenmax > 8) ? 8 : lenmax);
			send_match(off, len, 8'($urandom_range(255)));
		end else if (r < 88) begin
			// short match: only the next byte comes out
			send_match($urandom_range(255), $urandom_range(2), 8'($urandom_range(255)));
		end else begin
			if (r < 94) begin
				// offset past the produced bytes, or copy longer than its offset
				if (stream_bytes >= 255 || $urandom_range(1) == 1) begin
					off = $urandom_range(126);
					len = $urandom_range((off < 3) ? 3 : off + 1, 127);
				end else begin
					off = $urandom_range(stream_bytes + 1, 255);
					len = $urandom_range(3, 127);
				end
				send_match(off, len, 8'($urandom_range(255)));
			end else begin
				// stray byte, sometimes flagged as a stream start
				if ($urandom_range(1) == 1) begin
					start_next = 1'b1;
					stream_bytes = 0;
				end
				send_byte(8'($urandom_range(255)));
			end
			if ($urandom_range(1) == 1) begin
				start_next = 1'b1;
				stream_bytes = 0;
			end
		end
	endtask

	// Receiver: random stalls, plus a long hold-off on request
	initial begin
		int served;
		served = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request != served) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				served++;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Main sequence
	initial begin
		int                 target;
		logic [COUNT_W-1:0] lim;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// limit of one: second literal overflows, then the stream stays halted
		write_limit(COUNT_W'(1));
		send_byte(8'hFF);
		send_byte(8'h80);
		send_byte(8'h85);
		settle();

		// literals, a copy, a short match, a bad offset, then an overlapping copy
		write_limit(COUNT_MAX);
		send_byte(8'hFF);
		send_byte(8'h80);
		send_byte(8'hAA);
		send_match(3, 3, 8'h7F);
		send_match(0, 2, 8'hFF);
		send_match(100, 3, 8'h11);
		send_byte(8'h7F);
		start_next = 1'b1;
		send_byte(8'h81);
		send_byte(8'h82);
		send_match(1, 3, 8'h55);
		settle();

		// random phases with different idling and limits
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					gap_pct = 0;
					stall_pct = 0;
					lim = COUNT_MAX;
				end
				1: begin
					gap_pct = 60;
					stall_pct = 0;
					lim = COUNT_W'($urandom_range(20, 120));
				end
				2: begin
					gap_pct = 0;
					stall_pct = 60;
					lim = LIMIT_RESET;
				end
				default: begin
					gap_pct = 33;
					stall_pct = 33;
					lim = COUNT_W'($urandom_range(1, 60));
				end
			endcase
			write_limit(lim);
			// in the first phase the receiver holds off while items keep coming, so the block backs up
			if (p == 0)
				hold_request++;
			target = items_sent + PHASE_ITEMS;
			if (p == 2) begin
				while (items_sent < target - PHASE_ITEMS / 2)
					random_token();
				settle();
			end
			while (items_sent < target)
				random_token();
			settle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog
	initial begin
		#(TIMEOUT_NS);
		$display("Mismatches found");
		$finish;
	end

endmodule
